// ----- sv/rdc_pkg.sv -----
// Shared types, constants and the digit-to-ASCII mapping of the radix digit converter.
package rdc_pkg;

  localparam int VALUE_W = 63;
  localparam int CHAR_W  = 7;
  localparam int RADIX_W = 5;
  localparam int DIGIT_W = 4;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [RADIX_W-1:0] radix_t;
  typedef logic [DIGIT_W-1:0] digit_t;

  localparam radix_t RADIX_RESET = 5'd10;
  localparam radix_t RADIX_MIN   = 5'd2;
  localparam radix_t RADIX_MAX   = 5'd16;

  localparam char_t ASCII_ZERO    = 7'd48;
  localparam char_t ASCII_UPPER_A = 7'd65;
  localparam digit_t DECIMAL_TEN  = 4'd10;

  function automatic char_t digit_to_ascii(input digit_t d);
    char_t c;
    if (d < DECIMAL_TEN) begin
      c = ASCII_ZERO + char_t'(d);
    end else begin
      c = ASCII_UPPER_A + char_t'(d - DECIMAL_TEN);
    end
    return c;
  endfunction

endpackage

// ----- sv/radix_digit_converter.sv -----
// Radix digit converter: bit-serial division into a digit store, then ASCII emission MSD first.
// Each digit takes one division pass (one quotient bit per cycle); the digits are then emitted
// one result per cycle. A new value is taken only while idle, and busy stays high from start
// to the last read.
// Results cannot be stalled; strobe marks each one for a single cycle.
// Synchronous reset clears control state and sets the radix to ten.
module radix_digit_converter #(
  parameter int MAX_DIGITS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  rdc_pkg::value_t value,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  rdc_pkg::radix_t cfg_data,
  output logic           strobe,
  output rdc_pkg::char_t digit_char,
  output logic           last
);
  import rdc_pkg::*;

  localparam int LIM    = (MAX_DIGITS > 63) ? 63 : MAX_DIGITS;
  localparam int IDX_W  = (LIM > 1) ? $clog2(LIM) : 1;
  localparam int BCNT_W = $clog2(VALUE_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state;
  radix_t            radix;
  radix_t            divisor;
  value_t            quo;
  digit_t            rem;
  logic              nz;
  logic [BCNT_W-1:0] bit_cnt;
  logic [IDX_W-1:0]  cnt;
  logic [IDX_W-1:0]  rd_addr;
  digit_t            rd_data;
  logic              rd_last;
  logic              rd_vld;

  digit_t            mem [LIM];

  radix_t            trial;
  logic              qbit;
  digit_t            rem_next;
  logic              nz_next;
  radix_t            rclamp;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign strobe    = rd_vld;
  assign last      = rd_last;
  assign digit_char = digit_to_ascii(rd_data);

  always_comb begin
    trial = {rem, quo[VALUE_W-1]};
    qbit  = (trial >= divisor);
    if (qbit) begin
      rem_next = digit_t'(trial - divisor);
    end else begin
      rem_next = trial[DIGIT_W-1:0];
    end
    nz_next = nz | qbit;
    priority if (radix < RADIX_MIN) begin
      rclamp = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      rclamp = RADIX_MAX;
    end else begin
      rclamp = radix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      radix  <= RADIX_RESET;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        radix <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state   <= ST_DIV;
            divisor <= rclamp;
            quo     <= value;
            rem     <= '0;
            nz      <= 1'b0;
            bit_cnt <= '0;
            cnt     <= '0;
          end
        end
        ST_DIV: begin
          quo <= {quo[VALUE_W-2:0], qbit};
          if (bit_cnt == BCNT_W'(VALUE_W - 1)) begin
            mem[cnt] <= rem_next;
            bit_cnt  <= '0;
            rem      <= '0;
            nz       <= 1'b0;
            if (!nz_next || cnt == IDX_W'(LIM - 1)) begin
              state   <= ST_EMIT;
              rd_addr <= cnt;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end else begin
            bit_cnt <= bit_cnt + 1'b1;
            rem     <= rem_next;
            nz      <= nz_next;
          end
        end
        ST_EMIT: begin
          rd_data <= mem[rd_addr];
          rd_last <= (rd_addr == '0);
          rd_vld  <= 1'b1;
          rd_addr <= rd_addr - 1'b1;
          if (rd_addr == '0) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- verif/tb_radix_digit_converter.sv -----
// Self-checking testbench for radix_digit_converter: directed table, then random items per radix.
module tb_radix_digit_converter;
  import rdc_pkg::*;

  localparam int MAX_DIGITS  = 64;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int N_ROWS      = 24;
  localparam value_t VALUE_TOP = 63'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    char_t ch;
    logic  fin;
  } digit_exp_t;

  // text: expected digits right-aligned, all zero when the predictor supplies them
  typedef struct packed {
    radix_t       rdx;
    value_t       val;
    logic [159:0] text;
  } stim_row_t;

  logic    clk;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  value_t  value = '0;
  logic    cfg_valid = 1'b0;
  radix_t  cfg_data = RADIX_RESET;
  logic    busy;
  logic    cfg_ready;
  logic    strobe;
  char_t   digit_char;
  logic    last;

  digit_exp_t pending_digits[$];
  digit_exp_t head;
  radix_t     cur_radix = RADIX_RESET;
  int         errors = 0;
  int         items_sent = 0;
  int         digits_seen = 0;
  int         radix_writes = 0;
  int         cycle_count = 0;

  stim_row_t stim_table [N_ROWS] = '{
    '{5'd10, 63'd0,                  "0"},
    '{5'd10, 63'd7,                  "7"},
    '{5'd10, 63'd1234567890,         ""},
    '{5'd10, VALUE_TOP,              "9223372036854775807"},
    '{5'd16, 63'd0,                  "0"},
    '{5'd16, 63'd255,                "FF"},
    '{5'd16, 63'h7EDC_BA98_7654_3210, "7EDCBA9876543210"},
    '{5'd16, 63'h0123_4567_89AB_CDEF, "123456789ABCDEF"},
    '{5'd16, VALUE_TOP,              "7FFFFFFFFFFFFFFF"},
    '{5'd2,  63'd0,                  "0"},
    '{5'd2,  63'd5,                  "101"},
    '{5'd2,  VALUE_TOP,              ""},
    '{5'd2,  63'h4000_0000_0000_0000, ""},
    '{5'd0,  63'd6,                  "110"},
    '{5'd1,  63'd3,                  "11"},
    '{5'd17, 63'd15,                 "F"},
    '{5'd31, 63'd171,                "AB"},
    '{5'd31, VALUE_TOP,              "7FFFFFFFFFFFFFFF"},
    '{5'd8,  VALUE_TOP,              ""},
    '{5'd3,  VALUE_TOP,              ""},
    '{5'd7,  63'd48,                 "66"},
    '{5'd9,  63'd80,                 "88"},
    '{5'd15, 63'd14,                 "E"},
    '{5'd10, 63'd10,                 "10"}
  };

  radix_digit_converter #(.MAX_DIGITS(MAX_DIGITS)) DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .strobe     (strobe),
    .digit_char (digit_char),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Repeated division, LSD first, then queued MSD first.
  function automatic void predict_digits(input value_t v);
    logic [63:0] n;
    logic [63:0] base;
    digit_t      digs [64];
    int          cnt;
    int          lim;
    int          k;
    digit_exp_t  e;
    base = 64'(cur_radix);
    if (base < 64'(RADIX_MIN)) base = 64'(RADIX_MIN);
    if (base > 64'(RADIX_MAX)) base = 64'(RADIX_MAX);
    lim = (MAX_DIGITS > 63) ? 63 : MAX_DIGITS;
    if (lim < 1) lim = 1;
    n = {1'b0, v};
    cnt = 0;
    do begin
      digs[cnt] = digit_t'(n % base);
      cnt++;
      n = n / base;
    end while (n != 0 && cnt < lim);
    for (k = cnt - 1; k >= 0; k--) begin
      e.ch  = (digs[k] < DECIMAL_TEN) ? ASCII_ZERO + char_t'(digs[k])
                                      : ASCII_UPPER_A + char_t'(digs[k] - DECIMAL_TEN);
      e.fin = (k == 0);
      pending_digits.push_back(e);
    end
  endfunction

  function automatic void queue_typed_digits(input logic [159:0] text);
    digit_exp_t e;
    int         i;
    int         n_chars;
    n_chars = 0;
    for (i = 19; i >= 0; i--) begin
      if (text[i*8 +: 8] != 8'd0) n_chars++;
    end
    for (i = n_chars - 1; i >= 0; i--) begin
      e.ch  = char_t'(text[i*8 +: 8]);
      e.fin = (i == 0);
      pending_digits.push_back(e);
    end
  endfunction

  function automatic value_t random_value();
    int          w;
    logic [63:0] raw;
    w   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 20);
    raw = {$urandom, $urandom};
    return value_t'(raw & ((64'd1 << w) - 64'd1));
  endfunction

  task automatic send_value(input value_t v, input logic [159:0] text);
    value <= v;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (text == '0) predict_digits(v);
    else queue_typed_digits(text);
    items_sent++;
  endtask

  task automatic maybe_idle(input bit allow);
    if (allow && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_digits.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_radix(input radix_t r);
    drain();
    cfg_data  <= r;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_radix = r;
    radix_writes++;
  endtask

  initial begin
    int     i;
    int     ph;
    int     j;
    radix_t r;
    rst <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < N_ROWS; i++) begin
      if (stim_table[i].rdx != cur_radix) write_radix(stim_table[i].rdx);
      send_value(stim_table[i].val, stim_table[i].text);
      maybe_idle(1'b1);
    end

    // phases 3 and 7 run without gaps; phase 7 is back at the reset radix
    for (ph = 0; ph < 8; ph++) begin
      r = (ph == 7) ? RADIX_RESET : radix_t'($urandom_range(0, 31));
      if (r != cur_radix) write_radix(r);
      for (j = 0; j < 17; j++) begin
        send_value(random_value(), '0);
        if (ph == 2 && j == 10) drain();
        else maybe_idle(ph != 3 && ph != 7);
      end
    end

    start <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);

    $display("Sent %0d values and checked %0d digits", items_sent, digits_seen);
    $display("across %0d radix writes, out-of-range radices included", radix_writes);
    if (errors == 0) begin
      $display("radix_digit_converter: match");
    end else begin
      $display("radix_digit_converter: mismatch");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (pending_digits.size() == 0) begin
        $display("%0t: unexpected digit %c (%0d) last=%0b", $time, digit_char, digit_char, last);
        errors++;
      end else begin
        head = pending_digits.pop_front();
        digits_seen++;
        if (digit_char !== head.ch) begin
          $display("%0t: digit_char expected %c (%0d), got %c (%0d)",
                   $time, head.ch, head.ch, digit_char, digit_char);
          errors++;
        end
        if (last !== head.fin) begin
          $display("%0t: last expected %0b, got %0b", $time, head.fin, last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d digits outstanding", $time, pending_digits.size());
      $display("radix_digit_converter: mismatch");
      $finish;
    end
  end

endmodule
